@@ rtl/assert_macros.svh @@
// assertion macros shared by the rune range set engine rtl
// each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RRSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RRSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rrse_pkg.sv @@
// shared types, codes and helpers for the rune range set engine
// no dependencies
`default_nettype none

package rrse_pkg;

    localparam int DEF_MAX_RANGES = 64;
    localparam int DEF_RUNE_LIMIT = 1114111;

    localparam int RUNE_W      = 21;
    localparam int MODE_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;
    localparam int LETTERS     = 26;
    localparam int UPPER_BASE  = 65;   // 'A'
    localparam int LOWER_BASE  = 97;   // 'a'

    localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CONTAINS = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NEGATE   = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_MODE = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_CONTAINS,
        OP_REMOVE,
        OP_NEGATE
    } op_t;

    // sequencer to merge unit
    typedef struct packed {
        logic start;
        logic item_vld;
        logic tail;
        op_t  op;
    } unit_ctrl_t;

    // merge unit back to sequencer
    typedef struct packed {
        logic take_new;
        logic found;
        logic covered;
        logic ovf;
    } unit_stat_t;

    // letters whose code lies inside [lo, hi]
    function automatic logic [LETTERS-1:0] letter_span(
        input logic [RUNE_W-1:0] lo,
        input logic [RUNE_W-1:0] hi,
        input int unsigned       base
    );
        logic [LETTERS-1:0] m;
        logic [RUNE_W-1:0]  c;
        m = '0;
        for (int b = 0; b < LETTERS; b++)
        begin
            c    = RUNE_W'(base + b);
            m[b] = (lo <= c) && (c <= hi);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

@@ rtl/rrse_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module rrse_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ rtl/rrse_merge_unit.sv @@
// shared compare and merge unit: consumes one table entry per cycle, none while an
// add takes its new range in, and emits at most one rebuilt range; depends on rrse_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rrse_merge_unit
    import rrse_pkg::*;
#(
    parameter int MAX_RANGES = DEF_MAX_RANGES,
    parameter int RUNE_LIMIT = DEF_RUNE_LIMIT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire unit_ctrl_t                          ctrl,
    input  wire logic [RUNE_W-1:0]                   ent_s,
    input  wire logic [RUNE_W-1:0]                   ent_e,
    input  wire logic [RUNE_W-1:0]                   new_lo,
    input  wire logic [RUNE_W-1:0]                   new_hi,
    output logic                                     wr_en,
    output logic [$clog2(MAX_RANGES)-1:0]            wr_idx,
    output logic [RUNE_W-1:0]                        wr_s,
    output logic [RUNE_W-1:0]                        wr_e,
    output unit_stat_t                               stat,
    output logic [$clog2(MAX_RANGES+1)-1:0]          wcnt,
    output logic [RUNE_W-1:0]                        sum
);

    localparam int AW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam logic [RUNE_W-1:0] LIMIT = RUNE_W'(RUNE_LIMIT);
    localparam logic [CW-1:0]     FULL  = CW'(MAX_RANGES);

    logic              acc_v_reg, acc_v_next;
    logic [RUNE_W-1:0] acc_s_reg, acc_s_next;
    logic [RUNE_W-1:0] acc_e_reg, acc_e_next;
    logic              ins_reg, ins_next;
    logic [RUNE_W-1:0] nlo_reg, nlo_next;
    logic [CW-1:0]     wcnt_reg;
    logic [RUNE_W-1:0] sum_reg;
    logic              found_reg, found_next;
    logic              covered_reg, covered_next;
    logic              ovf_reg;

    logic              take_new;
    logic [RUNE_W-1:0] x_s, x_e;
    logic              em_v;
    logic [RUNE_W-1:0] em_s, em_e;
    logic              full;

    always_comb
    begin
        take_new = (ctrl.op == OP_ADD) && ctrl.item_vld && !ins_reg
                   && (ctrl.tail || (new_lo <= ent_s));
        x_s = take_new ? new_lo : ent_s;
        x_e = take_new ? new_hi : ent_e;

        em_v         = 1'b0;
        em_s         = acc_s_reg;
        em_e         = acc_e_reg;
        acc_v_next   = acc_v_reg;
        acc_s_next   = acc_s_reg;
        acc_e_next   = acc_e_reg;
        ins_next     = ins_reg;
        nlo_next     = nlo_reg;
        found_next   = found_reg;
        covered_next = covered_reg;

        if (ctrl.item_vld)
        begin
            case (ctrl.op)
                OP_ADD:
                begin
                    if (ctrl.tail && !take_new)
                    begin
                        // flush the range still being built
                        em_v = acc_v_reg;
                    end
                    else
                    begin
                        if (!take_new && (ent_s <= new_lo) && (new_hi <= ent_e))
                        begin
                            covered_next = 1'b1;
                        end
                        if (take_new)
                        begin
                            ins_next = 1'b1;
                        end
                        if (!acc_v_reg)
                        begin
                            acc_v_next = 1'b1;
                            acc_s_next = x_s;
                            acc_e_next = x_e;
                        end
                        else if ({1'b0, x_s} <= ({1'b0, acc_e_reg} + (RUNE_W+1)'(1)))
                        begin
                            // overlapping or abutting: extend
                            if (x_e > acc_e_reg)
                            begin
                                acc_e_next = x_e;
                            end
                        end
                        else
                        begin
                            em_v       = 1'b1;
                            acc_s_next = x_s;
                            acc_e_next = x_e;
                        end
                    end
                end
                OP_CONTAINS:
                begin
                    if (!ctrl.tail && (ent_s <= new_lo) && (new_lo <= ent_e))
                    begin
                        found_next = 1'b1;
                    end
                end
                OP_REMOVE:
                begin
                    if (!ctrl.tail && (ent_s <= new_lo))
                    begin
                        em_v = 1'b1;
                        em_s = ent_s;
                        em_e = (ent_e > new_lo) ? new_lo : ent_e;
                    end
                end
                OP_NEGATE:
                begin
                    if (!ctrl.tail)
                    begin
                        if (ent_s > nlo_reg)
                        begin
                            em_v = 1'b1;
                            em_s = nlo_reg;
                            em_e = ent_s - RUNE_W'(1);
                        end
                        nlo_next = ent_e + RUNE_W'(1);
                    end
                    else if (nlo_reg <= LIMIT)
                    begin
                        em_v = 1'b1;
                        em_s = nlo_reg;
                        em_e = LIMIT;
                    end
                end
                default:
                begin
                    em_v = 1'b0;
                end
            endcase
        end

        full  = (wcnt_reg == FULL);
        wr_en = em_v && !full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_v_reg   <= 1'b0;
            ins_reg     <= 1'b0;
            wcnt_reg    <= '0;
            found_reg   <= 1'b0;
            covered_reg <= 1'b0;
            ovf_reg     <= 1'b0;
        end
        else if (ctrl.start)
        begin
            acc_v_reg   <= 1'b0;
            ins_reg     <= 1'b0;
            wcnt_reg    <= '0;
            found_reg   <= 1'b0;
            covered_reg <= 1'b0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            acc_v_reg   <= acc_v_next;
            ins_reg     <= ins_next;
            found_reg   <= found_next;
            covered_reg <= covered_next;
            ovf_reg     <= ovf_reg | (em_v && full);
            if (wr_en)
            begin
                wcnt_reg <= wcnt_reg + CW'(1);
            end
        end
    end

    // payload side
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            nlo_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            nlo_reg <= nlo_next;
            if (wr_en)
            begin
                sum_reg <= sum_reg + (em_e - em_s) + RUNE_W'(1);
            end
        end
        acc_s_reg <= acc_s_next;
        acc_e_reg <= acc_e_next;
    end

    assign wr_idx = wcnt_reg[AW-1:0];
    assign wr_s   = em_s;
    assign wr_e   = em_e;
    assign wcnt   = wcnt_reg;
    assign sum    = sum_reg;
    assign stat   = '{take_new: take_new, found: found_reg,
                      covered: covered_reg, ovf: ovf_reg};

    `RRSE_ASSERT_NOW(a_wr_in_table, wr_en, (wcnt_reg < FULL), "write beyond table")
    `RRSE_ASSERT_NEXT(a_ovf_sticky, (ovf_reg && !ctrl.start), ovf_reg, "overflow flag lost")

endmodule

`default_nettype wire

@@ rtl/rune_range_set_engine_core.sv @@
// top level of the rune range set engine: handshake, sequencer, class state
// depends on rrse_pkg, rrse_ram, rrse_merge_unit and assert_macros.svh
//
// usage
//   input channel: mode, range_low, range_high with in_valid / in_stall; a beat
//   is taken when in_valid is high and in_stall is low
//   output channel: changed, found, status, total_runes, stored_ranges,
//   folds_ascii with out_valid / out_stall; one result beat per input beat
//   clear, invalid modes, empty adds and remove-above at or over the limit
//   finish without a sweep; every other operation sweeps the range table
//   through the merge unit, one entry per cycle, set by the single read
//   port of the table memory, pausing while an add takes its new range in
//   the table lives in one ram split in two halves; a sweep reads the live
//   half and writes the rebuilt table into the other, which becomes live
//   only when the operation succeeds, so a full table leaves everything alone
//   in_stall is high from acceptance until the result has been loaded into the
//   output register; a result held by out_stall does not block the next beat
//   being accepted, only the load of the result that follows it
//   reset (rst_n, asynchronous, active low) empties the class at once; the
//   ram needs no clearing pass since only entries below the count are read
`default_nettype none
`include "assert_macros.svh"

module rune_range_set_engine_core
    import rrse_pkg::*;
#(
    parameter int MAX_RANGES = DEF_MAX_RANGES,
    parameter int RUNE_LIMIT = DEF_RUNE_LIMIT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [MODE_W-1:0]      mode,
    input  wire logic [RUNE_W-1:0]      range_low,
    input  wire logic [RUNE_W-1:0]      range_high,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic                        changed,
    output logic                        found,
    output logic [STATUS_W-1:0]         status,
    output logic [RUNE_W-1:0]           total_runes,
    output logic [COUNT_OUT_W-1:0]      stored_ranges,
    output logic                        folds_ascii
);

    localparam int AW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam logic [RUNE_W-1:0] LIMIT = RUNE_W'(RUNE_LIMIT);
    localparam logic [CW-1:0]     FULL  = CW'(MAX_RANGES);
    localparam logic [RUNE_W:0]   TOTAL_MAX = {1'b0, LIMIT} + (RUNE_W+1)'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_COMMIT,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // class state
    logic [CW-1:0]      count_reg;
    logic [RUNE_W-1:0]  total_reg;
    logic [LETTERS-1:0] upper_reg;
    logic [LETTERS-1:0] lower_reg;
    logic               bank_reg;

    // current operation
    op_t               op_reg;
    logic [RUNE_W-1:0] lo_reg;
    logic [RUNE_W-1:0] hi_reg;
    logic [CW-1:0]     di_reg;
    logic [CW-1:0]     di_next;
    logic              res_changed_reg;
    logic              res_found_reg;
    logic [STATUS_W-1:0] res_status_reg;

    // output register
    logic                   out_valid_reg;
    logic                   changed_reg;
    logic                   found_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [RUNE_W-1:0]      total_out_reg;
    logic [COUNT_OUT_W-1:0] ranges_out_reg;
    logic                   folds_reg;

    logic              accept;
    logic              out_take;
    logic              out_free;
    logic [RUNE_W-1:0] hi_clamp;
    logic              tail;
    logic              consume;

    unit_ctrl_t        uctrl;
    unit_stat_t        ustat;
    logic              u_wr_en;
    logic [AW-1:0]     u_wr_idx;
    logic [RUNE_W-1:0] u_wr_s, u_wr_e;
    logic [CW-1:0]     u_wcnt;
    logic [RUNE_W-1:0] u_sum;

    logic [2*RUNE_W-1:0] rd_data;
    logic [AW:0]         rd_addr;
    logic [AW:0]         wr_addr;

    assign accept   = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign hi_clamp = (range_high > LIMIT) ? LIMIT : range_high;
    assign tail     = (di_reg >= count_reg);
    assign consume  = !ustat.take_new;

    // next read index: replay the same entry when the new range goes in first
    always_comb
    begin
        di_next = di_reg;
        case (state_reg)
            ST_PREP:
            begin
                di_next = '0;
            end
            ST_SCAN:
            begin
                if (consume && !tail)
                begin
                    di_next = di_reg + CW'(1);
                end
            end
            default:
            begin
                di_next = di_reg;
            end
        endcase
    end

    assign rd_addr = {bank_reg, di_next[AW-1:0]};
    assign wr_addr = {~bank_reg, u_wr_idx};

    assign uctrl = '{start: (state_reg == ST_PREP), item_vld: (state_reg == ST_SCAN),
                     tail: tail, op: op_reg};

    rrse_ram #(
        .WIDTH (2 * RUNE_W),
        .DEPTH (2 * (2 ** AW))
    ) u_table (
        .clk     (clk),
        .wr_en   (u_wr_en),
        .wr_addr (wr_addr),
        .wr_data ({u_wr_s, u_wr_e}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rrse_merge_unit #(
        .MAX_RANGES (MAX_RANGES),
        .RUNE_LIMIT (RUNE_LIMIT)
    ) u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (uctrl),
        .ent_s  (rd_data[2*RUNE_W-1:RUNE_W]),
        .ent_e  (rd_data[RUNE_W-1:0]),
        .new_lo (lo_reg),
        .new_hi (hi_reg),
        .wr_en  (u_wr_en),
        .wr_idx (u_wr_idx),
        .wr_s   (u_wr_s),
        .wr_e   (u_wr_e),
        .stat   (ustat),
        .wcnt   (u_wcnt),
        .sum    (u_sum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            total_reg       <= '0;
            upper_reg       <= '0;
            lower_reg       <= '0;
            bank_reg        <= 1'b0;
            op_reg          <= OP_ADD;
            lo_reg          <= '0;
            hi_reg          <= '0;
            di_reg          <= '0;
            res_changed_reg <= 1'b0;
            res_found_reg   <= 1'b0;
            res_status_reg  <= STATUS_OK;
            out_valid_reg   <= 1'b0;
            changed_reg     <= 1'b0;
            found_reg       <= 1'b0;
            status_reg      <= STATUS_OK;
            total_out_reg   <= '0;
            ranges_out_reg  <= '0;
            folds_reg       <= 1'b0;
        end
        else
        begin
            di_reg <= di_next;
            if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        lo_reg          <= range_low;
                        hi_reg          <= hi_clamp;
                        res_changed_reg <= 1'b0;
                        res_found_reg   <= 1'b0;
                        res_status_reg  <= STATUS_OK;
                        state_reg       <= ST_FINISH;
                        case (mode)
                            MODE_CLEAR:
                            begin
                                count_reg <= '0;
                                total_reg <= '0;
                                upper_reg <= '0;
                                lower_reg <= '0;
                            end
                            MODE_ADD:
                            begin
                                op_reg <= OP_ADD;
                                if (range_low <= hi_clamp)
                                begin
                                    state_reg <= ST_PREP;
                                end
                            end
                            MODE_CONTAINS:
                            begin
                                op_reg    <= OP_CONTAINS;
                                state_reg <= ST_PREP;
                            end
                            MODE_REMOVE:
                            begin
                                op_reg <= OP_REMOVE;
                                if (range_low < LIMIT)
                                begin
                                    state_reg <= ST_PREP;
                                end
                            end
                            MODE_NEGATE:
                            begin
                                op_reg    <= OP_NEGATE;
                                state_reg <= ST_PREP;
                            end
                            default:
                            begin
                                res_status_reg <= STATUS_BAD_MODE;
                            end
                        endcase
                    end
                end
                ST_PREP:
                begin
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (consume && tail)
                    begin
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_COMMIT:
                begin
                    state_reg <= ST_FINISH;
                    case (op_reg)
                        OP_ADD:
                        begin
                            if (ustat.covered)
                            begin
                                res_changed_reg <= 1'b0;
                            end
                            else if (ustat.ovf)
                            begin
                                res_status_reg <= STATUS_FULL;
                            end
                            else
                            begin
                                bank_reg        <= ~bank_reg;
                                count_reg       <= u_wcnt;
                                total_reg       <= u_sum;
                                upper_reg       <= upper_reg
                                                   | letter_span(lo_reg, hi_reg, UPPER_BASE);
                                lower_reg       <= lower_reg
                                                   | letter_span(lo_reg, hi_reg, LOWER_BASE);
                                res_changed_reg <= 1'b1;
                            end
                        end
                        OP_CONTAINS:
                        begin
                            res_found_reg <= ustat.found;
                        end
                        OP_REMOVE:
                        begin
                            bank_reg  <= ~bank_reg;
                            count_reg <= u_wcnt;
                            total_reg <= u_sum;
                            upper_reg <= upper_reg & letter_span('0, lo_reg, UPPER_BASE);
                            lower_reg <= lower_reg & letter_span('0, lo_reg, LOWER_BASE);
                        end
                        OP_NEGATE:
                        begin
                            if (ustat.ovf)
                            begin
                                res_status_reg <= STATUS_FULL;
                            end
                            else
                            begin
                                bank_reg  <= ~bank_reg;
                                count_reg <= u_wcnt;
                                total_reg <= u_sum;
                                upper_reg <= ~upper_reg;
                                lower_reg <= ~lower_reg;
                            end
                        end
                        default:
                        begin
                            res_status_reg <= STATUS_OK;
                        end
                    endcase
                end
                ST_FINISH:
                begin
                    // load the result beat once the output register is free
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        changed_reg    <= res_changed_reg;
                        found_reg      <= res_found_reg;
                        status_reg     <= res_status_reg;
                        total_out_reg  <= total_reg;
                        ranges_out_reg <= COUNT_OUT_W'(count_reg);
                        folds_reg      <= (upper_reg == lower_reg);
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign changed       = changed_reg;
    assign found         = found_reg;
    assign status        = status_reg;
    assign total_runes   = total_out_reg;
    assign stored_ranges = ranges_out_reg;
    assign folds_ascii   = folds_reg;

    `RRSE_ASSERT_NOW(a_count_bound, 1'b1, (count_reg <= FULL), "range count above table size")
    `RRSE_ASSERT_NOW(a_total_bound, 1'b1, ({1'b0, total_reg} <= TOTAL_MAX), "total out of range")
    `RRSE_ASSERT_NEXT(a_bank_commit, (state_reg != ST_COMMIT), $stable(bank_reg), "bank switched")
    `RRSE_ASSERT_NEXT(a_beat_drops, (out_take && state_reg != ST_FINISH), !out_valid_reg, "beat repeated")

endmodule

`default_nettype wire

@@ bench/rrse_class_checker.sv @@
// checker for the rune range set engine: watches both channels, keeps its own copy
// of the class, predicts each result beat and compares field by field
// depends on rrse_pkg
`timescale 1ns / 1ps
`default_nettype none

module rrse_class_checker
    import rrse_pkg::*;
#(
    parameter int MAX_RANGES = DEF_MAX_RANGES,
    parameter int RUNE_LIMIT = DEF_RUNE_LIMIT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_stall,
    input  wire logic [MODE_W-1:0]      mode,
    input  wire logic [RUNE_W-1:0]      range_low,
    input  wire logic [RUNE_W-1:0]      range_high,
    input  wire logic                   out_valid,
    input  wire logic                   out_stall,
    input  wire logic                   changed,
    input  wire logic                   found,
    input  wire logic [STATUS_W-1:0]    status,
    input  wire logic [RUNE_W-1:0]      total_runes,
    input  wire logic [COUNT_OUT_W-1:0] stored_ranges,
    input  wire logic                   folds_ascii,
    output int                          fail_count,
    output int                          pending,
    output int                          result_beats,
    output int                          full_hits,
    output int                          merges_seen
);

    typedef struct packed {
        logic                   changed;
        logic                   found;
        logic [STATUS_W-1:0]    status;
        logic [RUNE_W-1:0]      total_runes;
        logic [COUNT_OUT_W-1:0] stored_ranges;
        logic                   folds_ascii;
    } class_result_t;

    localparam logic [LETTERS-1:0] ALL_LETTERS = '1;

    class_result_t    expected_results[$];
    int unsigned      span_lo[MAX_RANGES];
    int unsigned      span_hi[MAX_RANGES];
    int unsigned      span_count;
    int unsigned      code_total;
    logic [LETTERS-1:0] upper_map;
    logic [LETTERS-1:0] lower_map;

    function automatic logic [LETTERS-1:0] letters_in(int unsigned lo, int unsigned hi,
                                                      int unsigned base);
        logic [LETTERS-1:0] m;
        m = '0;
        for (int b = 0; b < LETTERS; b++)
            m[b] = (lo <= base + b) && (base + b <= hi);
        return m;
    endfunction

    function automatic void class_add(int unsigned lo, int unsigned hi,
                                      output logic grew, output logic full);
        int unsigned i, j, k, newcount, nlo, nhi;
        int unsigned ts[MAX_RANGES];
        int unsigned te[MAX_RANGES];
        grew = 0;
        full = 0;
        if (hi > RUNE_LIMIT)
            hi = RUNE_LIMIT;
        if (lo > hi)
            return;
        for (k = 0; k < span_count; k++)
            if (span_lo[k] <= lo && hi <= span_hi[k])
                return;
        i = 0;
        while (i < span_count && span_hi[i] + 1 < lo)
            i++;
        j = i;
        while (j < span_count && span_lo[j] <= hi + 1)
            j++;
        newcount = span_count - (j - i) + 1;
        if (newcount > MAX_RANGES)
        begin
            full = 1;
            return;
        end
        nlo = lo;
        nhi = hi;
        if (j > i)
        begin
            if (span_lo[i] < nlo)
                nlo = span_lo[i];
            if (span_hi[j-1] > nhi)
                nhi = span_hi[j-1];
            for (k = i; k < j; k++)
                code_total -= span_hi[k] - span_lo[k] + 1;
            merges_seen++;
        end
        for (k = 0; k < i; k++)
        begin
            ts[k] = span_lo[k];
            te[k] = span_hi[k];
        end
        ts[i] = nlo;
        te[i] = nhi;
        for (k = j; k < span_count; k++)
        begin
            ts[i + 1 + k - j] = span_lo[k];
            te[i + 1 + k - j] = span_hi[k];
        end
        span_lo = ts;
        span_hi = te;
        span_count = newcount;
        code_total += nhi - nlo + 1;
        upper_map |= letters_in(lo, hi, UPPER_BASE);
        lower_map |= letters_in(lo, hi, LOWER_BASE);
        grew = 1;
    endfunction

    function automatic void class_trim_above(int unsigned r);
        int unsigned k, keep;
        keep = 0;
        if (r >= RUNE_LIMIT)
            return;
        upper_map &= letters_in(0, r, UPPER_BASE);
        lower_map &= letters_in(0, r, LOWER_BASE);
        for (k = 0; k < span_count; k++)
        begin
            if (span_lo[k] > r)
                code_total -= span_hi[k] - span_lo[k] + 1;
            else
            begin
                if (span_hi[k] > r)
                begin
                    code_total -= span_hi[k] - r;
                    span_hi[k] = r;
                end
                keep = k + 1;
            end
        end
        span_count = keep;
    endfunction

    function automatic void class_negate(output logic full);
        int unsigned k, n, nlo;
        int unsigned ts[MAX_RANGES + 1];
        int unsigned te[MAX_RANGES + 1];
        n = 0;
        nlo = 0;
        full = 0;
        for (k = 0; k < span_count; k++)
        begin
            if (span_lo[k] > nlo)
            begin
                ts[n] = nlo;
                te[n] = span_lo[k] - 1;
                n++;
            end
            nlo = span_hi[k] + 1;
        end
        if (nlo <= RUNE_LIMIT)
        begin
            ts[n] = nlo;
            te[n] = RUNE_LIMIT;
            n++;
        end
        if (n > MAX_RANGES)
        begin
            full = 1;
            return;
        end
        for (k = 0; k < n; k++)
        begin
            span_lo[k] = ts[k];
            span_hi[k] = te[k];
        end
        span_count = n;
        code_total = RUNE_LIMIT + 1 - code_total;
        upper_map = ALL_LETTERS & ~upper_map;
        lower_map = ALL_LETTERS & ~lower_map;
    endfunction

    function automatic class_result_t class_step(logic [MODE_W-1:0] m,
                                                 int unsigned lo, int unsigned hi);
        class_result_t res;
        logic full;
        res = '0;
        full = 0;
        case (m)
            MODE_CLEAR:
            begin
                span_count = 0;
                code_total = 0;
                upper_map = '0;
                lower_map = '0;
            end
            MODE_ADD:      class_add(lo, hi, res.changed, full);
            MODE_CONTAINS:
                for (int k = 0; k < span_count; k++)
                    if (span_lo[k] <= lo && lo <= span_hi[k])
                        res.found = 1;
            MODE_REMOVE:   class_trim_above(lo);
            MODE_NEGATE:   class_negate(full);
            default:       res.status = STATUS_BAD_MODE;
        endcase
        if (full)
        begin
            res.status = STATUS_FULL;
            full_hits++;
        end
        res.total_runes = RUNE_W'(code_total);
        res.stored_ranges = COUNT_OUT_W'(span_count);
        res.folds_ascii = (upper_map == lower_map);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        class_result_t want, got;
        if (!rst_n)
        begin
            expected_results.delete();
            span_count = 0;
            code_total = 0;
            upper_map = '0;
            lower_map = '0;
            fail_count = 0;
            pending = 0;
            result_beats = 0;
            full_hits = 0;
            merges_seen = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_results.insert(expected_results.size(),
                                        class_step(mode, range_low, range_high));
            if (out_valid && !out_stall)
            begin
                result_beats++;
                got = '{changed, found, status, total_runes, stored_ranges, folds_ascii};
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat %p", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want !== got)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch at beat %0d: expected %p got %p",
                                     result_beats, want, got);
                    end
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

`default_nettype wire

@@ bench/tb_rune_range_set_engine_core.sv @@
// top of the rune range set engine bench: clock, reset, stimulus, idling, verdict
// depends on rrse_pkg, rune_range_set_engine_core and rrse_class_checker
`timescale 1ns / 1ps
`default_nettype none

module tb_rune_range_set_engine_core;
    import rrse_pkg::*;

    logic                   clk = 0;
    logic                   rst_n = 0;
    logic                   in_valid = 0;
    logic                   in_stall;
    logic [MODE_W-1:0]      mode = '0;
    logic [RUNE_W-1:0]      range_low = '0;
    logic [RUNE_W-1:0]      range_high = '0;
    logic                   out_valid;
    logic                   out_stall = 0;
    logic                   changed;
    logic                   found;
    logic [STATUS_W-1:0]    status;
    logic [RUNE_W-1:0]      total_runes;
    logic [COUNT_OUT_W-1:0] stored_ranges;
    logic                   folds_ascii;

    int fail_count, pending, result_beats, full_hits, merges_seen;

    // idling percentages for each side, changed by phase
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    // long receiver hold-off, counted down by its own process
    int holdoff_cycles = 0;
    int beats_sent = 0;

    localparam int RUNE_TOP = DEF_RUNE_LIMIT;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    rune_range_set_engine_core DUT (.*);

    rrse_class_checker CHK (.*);

    // receiver side: random stalls, or a solid hold-off while one is pending
    always @(posedge clk)
    begin
        if (holdoff_cycles > 0)
        begin
            holdoff_cycles <= holdoff_cycles - 1;
            out_stall <= 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // code point biased towards the letters, the ends of the range, values above it and small values
    function automatic logic [RUNE_W-1:0] pick_rune();
        case ($urandom_range(9))
            0, 1, 2: return RUNE_W'($urandom_range(60, 130));
            3:       return RUNE_W'($urandom_range(RUNE_TOP - 3, RUNE_TOP));
            4:       return RUNE_W'($urandom_range(RUNE_TOP + 1, 2097151));
            5, 6:    return RUNE_W'($urandom_range(0, 4000));
            default: return RUNE_W'($urandom_range(0, RUNE_TOP));
        endcase
    endfunction

    // offer one beat and hold it until taken
    task automatic send_beat(logic [MODE_W-1:0] m, logic [RUNE_W-1:0] lo,
                             logic [RUNE_W-1:0] hi);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        mode <= m;
        range_low <= lo;
        range_high <= hi;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    // mostly adds of narrow ranges so the table fills, with probes, trims, negates, clears and bad modes mixed in
    task automatic random_beat();
        logic [RUNE_W-1:0] lo, hi;
        int pick;
        lo = pick_rune();
        hi = lo + RUNE_W'($urandom_range(0, 40));
        if ($urandom_range(9) == 0)
            hi = pick_rune();
        pick = $urandom_range(99);
        if (pick < 55)
            send_beat(MODE_ADD, lo, hi);
        else if (pick < 75)
            send_beat(MODE_CONTAINS, lo, RUNE_W'($urandom));
        else if (pick < 85)
            send_beat(MODE_REMOVE, (pick & 1) ? lo : RUNE_W'($urandom_range(2000, RUNE_TOP)),
                      RUNE_W'($urandom));
        else if (pick < 93)
            send_beat(MODE_NEGATE, RUNE_W'($urandom), RUNE_W'($urandom));
        else if (pick < 96)
            send_beat(MODE_CLEAR, RUNE_W'($urandom), RUNE_W'($urandom));
        else
            send_beat(MODE_W'($urandom_range(5, 7)), RUNE_W'($urandom), RUNE_W'($urandom));
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, every mode and each special case
        send_beat(MODE_CONTAINS, 21'd0, 21'd0);             // empty class
        send_beat(MODE_ADD, 21'd65, 21'd90);                // all upper letters
        send_beat(MODE_ADD, 21'd97, 21'd122);               // lower letters, folds
        send_beat(MODE_ADD, 21'd91, 21'd96);                // abutting both, merge
        send_beat(MODE_ADD, 21'd70, 21'd80);                // already covered
        send_beat(MODE_ADD, 21'd500, 21'd400);              // empty range
        send_beat(MODE_ADD, 21'h1FFFF0, 21'h1FFFFF);        // start above limit
        send_beat(MODE_ADD, 21'd1114100, 21'h1FFFFF);       // end clamped
        send_beat(MODE_CONTAINS, 21'd1114111, 21'd0);
        send_beat(MODE_CONTAINS, 21'h1FFFFF, 21'd0);        // probe above limit
        send_beat(MODE_REMOVE, 21'd100, 21'd0);             // straddles letters
        send_beat(MODE_REMOVE, 21'd1114111, 21'd0);         // at limit, no change
        send_beat(MODE_REMOVE, 21'h1FFFFF, 21'd0);
        send_beat(MODE_NEGATE, 21'd0, 21'd0);
        send_beat(MODE_NEGATE, 21'd0, 21'd0);
        send_beat(MODE_ADD, 21'd0, 21'd1114111);            // whole space
        send_beat(MODE_NEGATE, 21'd0, 21'd0);               // to empty
        send_beat(MODE_NEGATE, 21'd0, 21'd0);
        send_beat(MODE_REMOVE, 21'd0, 21'd0);
        send_beat(MODE_REMOVE, 21'd64, 21'd0);              // drops all letters
        for (int m = 5; m < 8; m++)
            send_beat(MODE_W'(m), 21'h1FFFFF, 21'h1FFFFF);
        send_beat(MODE_CLEAR, 21'h1FFFFF, 21'h1FFFFF);
        // fill the table with isolated points, then overflow it by add and negate
        for (int k = 0; k < 64; k++)
            send_beat(MODE_ADD, RUNE_W'(1000 + 3 * k), RUNE_W'(1000 + 3 * k));
        send_beat(MODE_ADD, 21'd5000, 21'd5000);            // table full
        send_beat(MODE_NEGATE, 21'd0, 21'd0);               // 65 gaps, full
        send_beat(MODE_ADD, 21'd1000, 21'd1200);            // collapse many

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 37 : 62) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 37 : 62) : 0;
            if (ph == 1)
                holdoff_cycles = 400;   // backs the block up behind its output
            for (int n = 0; n < 425; n++)
            begin
                if (n % 150 == 149)
                    send_beat(MODE_CLEAR, RUNE_W'($urandom), RUNE_W'($urandom));
                else
                    random_beat();
            end
        end
        in_valid <= 0;

        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("%0d beats sent, %0d results checked, %0d table-full outcomes, %0d merges",
                 beats_sent, result_beats, full_hits, merges_seen);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
